@@ src/rgbhsv_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Types and constants shared by the integer RGB to HSV converter.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

   localparam int ChanBits   = 8;
   localparam int HueBits    = 9;
   localparam int SatNumBits = 15;
   localparam int HueNumBits = 14;
   localparam int SatQBits   = 8;
   localparam int HueQBits   = 6;
   localparam int RemBits    = 9;
   localparam int DivSteps   = SatQBits;
   localparam int PipeDepth  = DivSteps + 3;

   localparam int SatShift   = 7;
   localparam logic [HueBits-1:0] RedBase   = 9'd0;
   localparam logic [HueBits-1:0] GreenBase = 9'd120;
   localparam logic [HueBits-1:0] BlueBase  = 9'd240;
   localparam logic [HueBits-1:0] FullTurn  = 9'd360;

   typedef struct packed {
      logic [ChanBits-1:0] red;
      logic [ChanBits-1:0] green;
      logic [ChanBits-1:0] blue;
   } req_type;

   typedef struct packed {
      logic [HueBits-1:0]  hue;
      logic [ChanBits-1:0] saturation;
      logic [ChanBits-1:0] brightness;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic [ChanBits-1:0] hi;
      logic [ChanBits-1:0] delta;
      logic [ChanBits-1:0] abs_diff;
      logic                neg;
      logic [HueBits-1:0]  base;
   } pre_type;

   typedef struct packed {
      logic                  valid;
      logic [ChanBits-1:0]   hi;
      logic [ChanBits-1:0]   delta;
      logic                  neg;
      logic [HueBits-1:0]    base;
      logic [SatNumBits-1:0] sat_num;
      logic [RemBits-1:0]    sat_rem;
      logic [SatQBits-1:0]   sat_q;
      logic [HueNumBits-1:0] hue_num;
      logic [RemBits-1:0]    hue_rem;
      logic [HueQBits-1:0]   hue_q;
   } div_type;

   // one restoring division step: the saturation quotient always, the hue quotient while k < HueQBits
   function automatic div_type div_step(input div_type s, input int k);
      div_type             d;
      logic [RemBits-1:0]  trial;
      d = s;
      trial = {s.sat_rem[RemBits-2:0], s.sat_num[4'(SatQBits-1-k)]};
      if (trial >= {1'b0, s.hi}) begin
         d.sat_rem = trial - {1'b0, s.hi};
         d.sat_q   = {s.sat_q[SatQBits-2:0], 1'b1};
      end else begin
         d.sat_rem = trial;
         d.sat_q   = {s.sat_q[SatQBits-2:0], 1'b0};
      end
      if (k < HueQBits) begin
         trial = {s.hue_rem[RemBits-2:0], s.hue_num[4'(HueQBits-1-k)]};
         if (trial >= {1'b0, s.delta}) begin
            d.hue_rem = trial - {1'b0, s.delta};
            d.hue_q   = {s.hue_q[HueQBits-2:0], 1'b1};
         end else begin
            d.hue_rem = trial;
            d.hue_q   = {s.hue_q[HueQBits-2:0], 1'b0};
         end
      end
      return d;
   endfunction

endpackage

@@ src/rgb_to_hsv_integer.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hsv_integer
// Pipelined integer RGB to HSV conversion with bit-per-stage dividers.
// ----------------------------------------------------------------------------
// an accepted request passes through pre_ff, num_ff, the div_ff stages and rsp_valid_ff to the rsp_valid strobe
// throughput: one request per cycle, busy is always low
// the eight-stage saturation divider sets the pipeline depth
// reset clears the valid bits of every stage, payload is not reset
// ----------------------------------------------------------------------------
module rgb_to_hsv_integer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  rgbhsv_pkg::req_type  req_pixel,
   output logic                 rsp_valid,
   output rgbhsv_pkg::rsp_type  rsp_hsv
);

   rgbhsv_pkg::pre_type pre_in, pre_ff;
   rgbhsv_pkg::div_type num_in, num_ff;
   rgbhsv_pkg::div_type div_in [rgbhsv_pkg::DivSteps];
   rgbhsv_pkg::div_type div_ff [rgbhsv_pkg::DivSteps];
   rgbhsv_pkg::rsp_type rsp_in, rsp_ff;
   logic                rsp_valid_in, rsp_valid_ff;

   logic                                red_max, green_max;
   logic [rgbhsv_pkg::ChanBits-1:0]     lo, hi;
   logic [rgbhsv_pkg::ChanBits:0]       diff;
   logic [rgbhsv_pkg::HueQBits-1:0]     q;
   logic [rgbhsv_pkg::HueBits-1:0]      base;

   assign busy = 1'b0;

   // sector, extremes and signed difference
   always_comb begin
      red_max   = (req_pixel.red >= req_pixel.green) && (req_pixel.red >= req_pixel.blue);
      green_max = !red_max && (req_pixel.green >= req_pixel.blue);
      hi = (req_pixel.red > req_pixel.green) ? req_pixel.red : req_pixel.green;
      if (req_pixel.blue > hi) hi = req_pixel.blue;
      lo = (req_pixel.red < req_pixel.green) ? req_pixel.red : req_pixel.green;
      if (req_pixel.blue < lo) lo = req_pixel.blue;
      if (red_max) begin
         diff = {1'b0, req_pixel.green} - {1'b0, req_pixel.blue};
         base = rgbhsv_pkg::RedBase;
      end else if (green_max) begin
         diff = {1'b0, req_pixel.blue} - {1'b0, req_pixel.red};
         base = rgbhsv_pkg::GreenBase;
      end else begin
         diff = {1'b0, req_pixel.red} - {1'b0, req_pixel.green};
         base = rgbhsv_pkg::BlueBase;
      end
      pre_in.valid    = start && !busy;
      pre_in.hi       = hi;
      pre_in.delta    = hi - lo;
      pre_in.neg      = diff[rgbhsv_pkg::ChanBits];
      pre_in.abs_diff = diff[rgbhsv_pkg::ChanBits] ?
                        rgbhsv_pkg::ChanBits'(-diff) : diff[rgbhsv_pkg::ChanBits-1:0];
      pre_in.base     = base;
   end

   // numerators: delta*128 and |diff|*60
   always_comb begin
      num_in.valid   = pre_ff.valid;
      num_in.hi      = pre_ff.hi;
      num_in.delta   = pre_ff.delta;
      num_in.neg     = pre_ff.neg;
      num_in.base    = pre_ff.base;
      num_in.sat_num = {pre_ff.delta, rgbhsv_pkg::SatShift'(0)};
      num_in.hue_num = {pre_ff.abs_diff, 6'b0} - {4'b0, pre_ff.abs_diff, 2'b0};
      num_in.sat_rem = rgbhsv_pkg::RemBits'(
                       num_in.sat_num[rgbhsv_pkg::SatNumBits-1:rgbhsv_pkg::SatQBits]);
      num_in.hue_rem = rgbhsv_pkg::RemBits'(
                       num_in.hue_num[rgbhsv_pkg::HueNumBits-1:rgbhsv_pkg::HueQBits]);
      num_in.sat_q   = '0;
      num_in.hue_q   = '0;
   end

   always_comb begin
      for (int k = 0; k < rgbhsv_pkg::DivSteps; k++) begin
         div_in[k] = rgbhsv_pkg::div_step((k == 0) ? num_ff : div_ff[(k == 0) ? 0 : k-1], k);
      end
   end

   // sign, offset and wrap
   always_comb begin
      rgbhsv_pkg::div_type last;
      last = div_ff[rgbhsv_pkg::DivSteps-1];
      q    = last.hue_q;
      rsp_valid_in      = last.valid;
      rsp_in.brightness = last.hi;
      rsp_in.saturation = (last.hi == '0) ? '0 : last.sat_q;
      if (last.delta == '0) begin
         rsp_in.hue = '0;
      end else if (last.neg) begin
         if (last.base < {3'b0, q}) begin
            rsp_in.hue = rgbhsv_pkg::FullTurn - {3'b0, q};
         end else begin
            rsp_in.hue = last.base - {3'b0, q};
         end
      end else begin
         rsp_in.hue = last.base + {3'b0, q};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ff.valid <= 1'b0;
         num_ff.valid <= 1'b0;
         for (int k = 0; k < rgbhsv_pkg::DivSteps; k++) begin
            div_ff[k].valid <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         pre_ff <= pre_in;
         num_ff <= num_in;
         for (int k = 0; k < rgbhsv_pkg::DivSteps; k++) begin
            div_ff[k] <= div_in[k];
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hsv   = rsp_ff;

   a_rsp_follows_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, rgbhsv_pkg::PipeDepth))
      else $error("result without matching request");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hsv.hue < rgbhsv_pkg::FullTurn)
      else $error("hue out of range");

   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hsv.saturation <= 8'd128)
      else $error("saturation out of range");

   a_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hsv.brightness == '0 |-> rsp_hsv.hue == '0 && rsp_hsv.saturation == '0)
      else $error("black pixel gives nonzero hue or saturation");

endmodule

@@ tb/rgb_to_hsv_integer_tb.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hsv_integer_tb
// Self-checking bench for the integer RGB to HSV converter. A table of corner
// pixels is sent first, some with hand-computed answers, then random pixels
// with random sender gaps. Every result is compared, in order of request, against
// the hand-computed answer of its row or else a behavioral HSV calculation.
// ----------------------------------------------------------------------------
module rgb_to_hsv_integer_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int  DegPerSector  = 60;
   localparam int  SatScale      = 1 << rgbhsv_pkg::SatShift;
   localparam int  RandomPixels  = 750;
   localparam int  QuietLimit    = 2000;
   localparam int  NumRows       = 22;
   localparam bit  KNOWN         = 1'b1;
   localparam bit  CALC          = 1'b0;
   localparam rgbhsv_pkg::rsp_type NO_HSV = '0;

   typedef struct packed {
      logic                known;
      rgbhsv_pkg::req_type px;
      rgbhsv_pkg::rsp_type hsv;
   } pixel_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   rgbhsv_pkg::req_type req = '0;
   logic                rsp_valid;
   rgbhsv_pkg::rsp_type rsp;

   logic                row_known = 1'b0;
   rgbhsv_pkg::rsp_type row_hsv   = '0;

   rgbhsv_pkg::rsp_type hsv_expected[$];
   rgbhsv_pkg::rsp_type want;
   int      mismatch_count = 0;
   int      quiet_cycles   = 0;
   bit      took_pixel;

   // known answers only where they are obvious, the rest is calculated
   pixel_row_type pixel_rows [NumRows] = '{
      {KNOWN, 8'd0,   8'd0,   8'd0,   9'd0,   8'd0,   8'd0  },
      {KNOWN, 8'd255, 8'd255, 8'd255, 9'd0,   8'd0,   8'd255},
      {KNOWN, 8'd1,   8'd1,   8'd1,   9'd0,   8'd0,   8'd1  },
      {KNOWN, 8'd255, 8'd0,   8'd0,   9'd0,   8'd128, 8'd255},
      {KNOWN, 8'd0,   8'd255, 8'd0,   9'd120, 8'd128, 8'd255},
      {KNOWN, 8'd0,   8'd0,   8'd255, 9'd240, 8'd128, 8'd255},
      {KNOWN, 8'd255, 8'd255, 8'd0,   9'd60,  8'd128, 8'd255},
      {KNOWN, 8'd0,   8'd255, 8'd255, 9'd180, 8'd128, 8'd255},
      {KNOWN, 8'd255, 8'd0,   8'd255, 9'd300, 8'd128, 8'd255},
      {KNOWN, 8'd1,   8'd0,   8'd0,   9'd0,   8'd128, 8'd1  },
      {CALC,  8'd255, 8'd0,   8'd1,   NO_HSV},
      {CALC,  8'd255, 8'd254, 8'd0,   NO_HSV},
      {CALC,  8'd128, 8'd64,  8'd200, NO_HSV},
      {CALC,  8'd254, 8'd255, 8'd253, NO_HSV},
      {CALC,  8'd10,  8'd20,  8'd30,  NO_HSV},
      {CALC,  8'd200, 8'd100, 8'd50,  NO_HSV},
      {CALC,  8'd7,   8'd3,   8'd5,   NO_HSV},
      {CALC,  8'd0,   8'd128, 8'd128, NO_HSV},
      {CALC,  8'd1,   8'd0,   8'd2,   NO_HSV},
      {CALC,  8'd100, 8'd100, 8'd99,  NO_HSV},
      {CALC,  8'd0,   8'd1,   8'd1,   NO_HSV},
      {CALC,  8'd170, 8'd85,  8'd255, NO_HSV}
   };

   always #6 clock = ~clock;

   rgb_to_hsv_integer u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_pixel (req),
      .rsp_valid (rsp_valid),
      .rsp_hsv   (rsp)
   );

   function automatic rgbhsv_pkg::rsp_type hsv_of(input rgbhsv_pkg::req_type px);
      int                  r, g, b, lo, hi, delta, hue, sat;
      rgbhsv_pkg::rsp_type res;
      r = px.red;
      g = px.green;
      b = px.blue;
      lo = (r < g) ? r : g;
      if (b < lo) lo = b;
      hi = (r > g) ? r : g;
      if (b > hi) hi = b;
      delta = hi - lo;
      hue = 0;
      sat = 0;
      if (hi != 0) begin
         sat = (delta * SatScale) / hi;
         if (delta != 0) begin
            if (r == hi) begin
               hue = int'(rgbhsv_pkg::RedBase) + ((g - b) * DegPerSector) / delta;
            end else if (g == hi) begin
               hue = int'(rgbhsv_pkg::GreenBase) + ((b - r) * DegPerSector) / delta;
            end else begin
               hue = int'(rgbhsv_pkg::BlueBase) + ((r - g) * DegPerSector) / delta;
            end
            if (hue < 0) hue += int'(rgbhsv_pkg::FullTurn);
         end
      end
      res.hue        = hue[rgbhsv_pkg::HueBits-1:0];
      res.saturation = sat[rgbhsv_pkg::ChanBits-1:0];
      res.brightness = hi[rgbhsv_pkg::ChanBits-1:0];
      return res;
   endfunction

   task automatic send_pixel(input rgbhsv_pkg::req_type px, input bit known,
                             input rgbhsv_pkg::rsp_type hsv);
      @(negedge clock);
      start     <= 1'b1;
      req       <= px;
      row_known <= known;
      row_hsv   <= hsv;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_for(input int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // scoreboard and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         took_pixel = start && !busy;
         if (took_pixel) begin
            hsv_expected.push_back(row_known ? row_hsv : hsv_of(req));
         end
         if (rsp_valid) begin
            if (hsv_expected.size() == 0) begin
               $display("%0t: expected no result, actual hue %0d sat %0d val %0d", $time,
                        rsp.hue, rsp.saturation, rsp.brightness);
               mismatch_count++;
            end else begin
               want = hsv_expected.pop_front();
               if (rsp.hue !== want.hue) begin
                  $display("%0t: hue expected %0d actual %0d", $time, want.hue, rsp.hue);
                  mismatch_count++;
               end
               if (rsp.saturation !== want.saturation) begin
                  $display("%0t: saturation expected %0d actual %0d", $time,
                           want.saturation, rsp.saturation);
                  mismatch_count++;
               end
               if (rsp.brightness !== want.brightness) begin
                  $display("%0t: brightness expected %0d actual %0d", $time,
                           want.brightness, rsp.brightness);
                  mismatch_count++;
               end
            end
         end
         if (took_pixel || rsp_valid) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QuietLimit) begin
               $display("%0t: watchdog expired", $time);
               $display("*** FAILED ***");
               $finish;
            end
         end
      end
   end

   initial begin
      rgbhsv_pkg::req_type px;
      int                  v, pick, lo_v, gap;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (pixel_rows[i]) begin
         send_pixel(pixel_rows[i].px, pixel_rows[i].known, pixel_rows[i].hsv);
         if ($urandom_range(0, 2) == 0) idle_for($urandom_range(1, 3));
      end

      for (int n = 0; n < RandomPixels; n++) begin
         case ($urandom_range(0, 9))
            0: begin
               v = $urandom_range(0, 255);
               px = '{red: 8'(v), green: 8'(v), blue: 8'(v)};
            end
            1: begin
               // two channels tied at the top
               v    = $urandom_range(1, 255);
               lo_v = $urandom_range(0, v - 1);
               pick = $urandom_range(0, 2);
               px.red   = (pick == 2) ? 8'(lo_v) : 8'(v);
               px.green = (pick == 1) ? 8'(lo_v) : 8'(v);
               px.blue  = (pick == 0) ? 8'(lo_v) : 8'(v);
            end
            2: begin
               px = '{red: 8'($urandom_range(0, 3)), green: 8'($urandom_range(0, 3)),
                      blue: 8'($urandom_range(0, 3))};
            end
            3: begin
               px.red   = ($urandom_range(0, 2) == 0) ? 8'($urandom) :
                          (($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255);
               px.green = ($urandom_range(0, 2) == 0) ? 8'($urandom) :
                          (($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255);
               px.blue  = ($urandom_range(0, 2) == 0) ? 8'($urandom) :
                          (($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255);
            end
            default: begin
               px = rgbhsv_pkg::req_type'(24'($urandom));
            end
         endcase
         send_pixel(px, CALC, NO_HSV);

         if (n == RandomPixels / 2) begin
            // hold off until the pipeline has drained
            @(negedge clock);
            start <= 1'b0;
            while (hsv_expected.size() != 0) @(posedge clock);
         end else if ((n % 150) >= 30) begin
            gap = $urandom_range(0, 99);
            if (gap >= 92) begin
               idle_for($urandom_range(10, 40));
            end else if (gap >= 60) begin
               idle_for($urandom_range(1, 3));
            end
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (hsv_expected.size() != 0) @(posedge clock);
      repeat (rgbhsv_pkg::PipeDepth + 4) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/rgbhsv_pkg.sv
src/rgb_to_hsv_integer.sv
tb/rgb_to_hsv_integer_tb.sv
